### rtl/core/minmax_normalize_rgba_pack_assert.svh
// assertion macros for the rgba pack block
`ifndef MINMAX_NORMALIZE_RGBA_PACK_ASSERT_SVH
`define MINMAX_NORMALIZE_RGBA_PACK_ASSERT_SVH
`ifndef ASSERT_OFF
`define MMNP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MMNP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define MMNP_ASSERT(lbl, prop, msg)
`define MMNP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/core/mmnp_pkg.sv
// shared widths, types and constants of the rgba pack block
package mmnp_pkg;
    localparam int SW     = 32;
    localparam int FB     = 16;
    localparam int SPW    = SW + 1;
    localparam int DW     = SW + 2;
    localparam int NW     = DW + 15;
    localparam int DENW   = SW + 9;
    localparam int QUW    = NW - 1 + FB;
    localparam int QW     = QUW + 1;
    localparam int IW     = QW - FB;
    localparam int SUMW   = QW + 2;
    localparam int LANES  = 4;
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef logic signed [SW-1:0] t_sample;

    localparam t_sample SMAX   = t_sample'({1'b0, {(SW-1){1'b1}}});
    localparam t_sample SMIN   = t_sample'({1'b1, {(SW-1){1'b0}}});
    localparam t_sample ONE_FX = t_sample'(longint'(1) << FB);

    typedef enum logic [1:0] {
        DEN_ZERO,
        DEN_ONE,
        DEN_THREE,
        DEN_DIFF
    } t_den_kind;

    typedef struct packed {
        logic signed [DW-1:0]  diff;
        logic signed [SPW-1:0] span;
        t_den_kind             kind;
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0] lanes;
        logic              avg_alpha;
    } t_entry;
endpackage

### rtl/core/mmnp_front.sv
// front end: config registers, bound gathering and per-channel setup
module mmnp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic               i_first_of_pass,
    input  logic signed [31:0] i_red_sample,
    input  logic signed [31:0] i_green_sample,
    input  logic signed [31:0] i_blue_sample,
    input  logic signed [31:0] i_alpha_sample,
    input  logic               i_alpha_present,
    input  logic               i_q_full,
    output logic               o_q_push,
    output mmnp_pkg::t_entry   o_q_entry
);
    import mmnp_pkg::*;

    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_IGNORE  = 3'd1;
    localparam logic [2:0] CFG_UMIN_RG = 3'd2;
    localparam logic [2:0] CFG_UMIN_BA = 3'd3;
    localparam logic [2:0] CFG_UMAX_RG = 3'd4;
    localparam logic [2:0] CFG_UMAX_BA = 3'd5;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_IGN_MAX = 2'd1;
    localparam logic [1:0] MODE_USER    = 2'd3;

    localparam logic [63:0] UMAX_RESET = {32'(ONE_FX), 32'(ONE_FX)};

    logic [1:0]  r_mode;
    logic [31:0] r_ignore;
    logic [63:0] r_umin_rg, r_umin_ba, r_umax_rg, r_umax_ba;

    t_sample    r_min [LANES];
    t_sample    r_max [LANES];
    logic [LANES-1:0] r_seen;
    t_sample    n_min [LANES];
    t_sample    n_max [LANES];
    logic [LANES-1:0] n_seen;

    t_sample s [LANES];
    t_sample umin [LANES];
    t_sample umax [LANES];
    t_sample b_mn [LANES];
    t_sample b_mx [LANES];
    t_sample lo_v [LANES];
    logic    b_ok [LANES];
    t_sample ign;
    logic    in_acc;

    assign s[0] = i_red_sample[SW-1:0];
    assign s[1] = i_green_sample[SW-1:0];
    assign s[2] = i_blue_sample[SW-1:0];
    assign s[3] = i_alpha_sample[SW-1:0];

    assign umin[0] = r_umin_rg[32 +: SW];
    assign umin[1] = r_umin_rg[0 +: SW];
    assign umin[2] = r_umin_ba[32 +: SW];
    assign umin[3] = r_umin_ba[0 +: SW];
    assign umax[0] = r_umax_rg[32 +: SW];
    assign umax[1] = r_umax_rg[0 +: SW];
    assign umax[2] = r_umax_ba[32 +: SW];
    assign umax[3] = r_umax_ba[0 +: SW];

    assign o_in_stall = i_q_full;
    assign in_acc     = i_in_valid && !i_q_full;
    assign o_q_push   = in_acc && i_action;
    assign ign        = (r_mode == MODE_IGN_MAX) ? SMAX : r_ignore[SW-1:0];

    // bound update on gather words
    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            n_min[c] = r_min[c];
            n_max[c] = r_max[c];
        end
        n_seen = r_seen;
        if (in_acc && !i_action) begin
            if (i_first_of_pass) begin
                for (int c = 0; c < LANES; c++) begin
                    n_min[c] = SMAX;
                    n_max[c] = SMIN;
                end
                n_seen = '0;
            end
            for (int c = 0; c < LANES; c++) begin
                if ((c < 3 || i_alpha_present) && s[c] != ign) begin
                    if (s[c] > n_max[c]) begin
                        n_max[c] = s[c];
                    end
                    if (s[c] < n_min[c]) begin
                        n_min[c] = s[c];
                    end
                    n_seen[c] = 1'b1;
                end
            end
        end
    end

    // channel setup for convert words
    always_comb begin
        o_q_entry.avg_alpha = !i_alpha_present && (r_mode != MODE_NONE);
        for (int c = 0; c < LANES; c++) begin
            b_mn[c] = (r_mode == MODE_USER) ? umin[c] : r_min[c];
            b_mx[c] = (r_mode == MODE_USER) ? umax[c] : r_max[c];
            b_ok[c] = (r_mode == MODE_USER) || r_seen[c];
            lo_v[c] = (b_mx[c] >= 0 && b_mx[c] <= ONE_FX) ? '0 : b_mn[c];
            o_q_entry.lanes[c].diff = '0;
            o_q_entry.lanes[c].span = '0;
            o_q_entry.lanes[c].kind = DEN_ZERO;
            if (r_mode == MODE_NONE) begin
                if (c == 3 && !i_alpha_present) begin
                    o_q_entry.lanes[c].diff = DW'(s[0]) + DW'(s[1]) + DW'(s[2]);
                    o_q_entry.lanes[c].kind = DEN_THREE;
                end else begin
                    o_q_entry.lanes[c].diff = DW'(s[c]);
                    o_q_entry.lanes[c].kind = DEN_ONE;
                end
            end else if (!b_ok[c]) begin
                o_q_entry.lanes[c].kind = DEN_ZERO;
            end else if (b_mx[c] == b_mn[c]) begin
                o_q_entry.lanes[c].diff = DW'(s[c]) - DW'(lo_v[c]);
                o_q_entry.lanes[c].kind = DEN_ONE;
            end else begin
                o_q_entry.lanes[c].diff = DW'(s[c]) - DW'(b_mn[c]);
                o_q_entry.lanes[c].span = SPW'(b_mx[c]) - SPW'(b_mn[c]);
                o_q_entry.lanes[c].kind = DEN_DIFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NONE;
            r_ignore  <= '0;
            r_umin_rg <= '0;
            r_umin_ba <= '0;
            r_umax_rg <= UMAX_RESET;
            r_umax_ba <= UMAX_RESET;
            for (int c = 0; c < LANES; c++) begin
                r_min[c] <= SMAX;
                r_max[c] <= SMIN;
            end
            r_seen <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODE:    r_mode    <= i_cfg_data[1:0];
                    CFG_IGNORE:  r_ignore  <= i_cfg_data[31:0];
                    CFG_UMIN_RG: r_umin_rg <= i_cfg_data;
                    CFG_UMIN_BA: r_umin_ba <= i_cfg_data;
                    CFG_UMAX_RG: r_umax_rg <= i_cfg_data;
                    CFG_UMAX_BA: r_umax_ba <= i_cfg_data;
                    default: ;
                endcase
            end
            for (int c = 0; c < LANES; c++) begin
                r_min[c] <= n_min[c];
                r_max[c] <= n_max[c];
            end
            r_seen <= n_seen;
        end
    end
endmodule

### rtl/core/mmnp_queue.sv
// short queue of setup words between front and back
`include "minmax_normalize_rgba_pack_assert.svh"
module mmnp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mmnp_pkg::t_entry i_entry,
    input  logic             i_pop,
    output mmnp_pkg::t_entry o_entry,
    output logic             o_full,
    output logic             o_empty
);
    import mmnp_pkg::*;

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_count;

    assign o_entry = r_mem[r_rp];
    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `MMNP_ASSERT(a_no_overflow, i_push |-> !o_full, "push into full queue")
    `MMNP_ASSERT(a_no_underflow, i_pop |-> !o_empty, "pop from empty queue")
    `MMNP_ASSERT(a_count_up, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "count")
    `MMNP_ASSERT_NEVER(a_count_range, r_count > QCW'(QDEPTH), "queue count out of range")
endmodule

### rtl/core/mmnp_div.sv
// radix-2 floor divider lane, quotient carries fb fraction bits
module mmnp_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [mmnp_pkg::NW-1:0]   i_num,
    input  logic signed [mmnp_pkg::DENW-1:0] i_den,
    output logic                             o_busy,
    output logic signed [mmnp_pkg::QW-1:0]   o_quot
);
    import mmnp_pkg::*;

    localparam int CW = $clog2(QUW);

    logic            r_busy;
    logic [CW-1:0]   r_cnt;
    logic [DENW-2:0] r_rem;
    logic [DENW-2:0] r_dv;
    logic [QUW-1:0]  r_quo;
    logic            r_neg;
    logic            r_zero;

    logic [DENW-1:0] trial;
    logic [DENW-1:0] sub;
    logic            ge;
    logic [NW-2:0]   num_mag;
    logic [DENW-2:0] den_mag;
    logic [QW-1:0]   mag;

    assign num_mag = i_num[NW-1] ? (NW-1)'(-i_num) : i_num[NW-2:0];
    assign den_mag = i_den[DENW-1] ? (DENW-1)'(-i_den) : i_den[DENW-2:0];
    assign trial   = {r_rem, r_quo[QUW-1]};
    assign ge      = trial >= {1'b0, r_dv};
    assign sub     = trial - {1'b0, r_dv};
    assign mag     = {1'b0, r_quo} + QW'(r_neg && (r_rem != '0));
    assign o_busy  = r_busy;
    assign o_quot  = r_zero ? '0 : (r_neg ? -mag : mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QUW - 1);
            r_rem  <= '0;
            r_quo  <= {num_mag, {FB{1'b0}}};
            r_dv   <= den_mag;
            r_neg  <= i_num[NW-1] ^ i_den[DENW-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= ge ? sub[DENW-2:0] : trial[DENW-2:0];
            r_quo <= {r_quo[QUW-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

### rtl/core/mmnp_back.sv
// back end: scaling divides, clamping, alpha average and output register
module mmnp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  mmnp_pkg::t_entry i_q_entry,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [31:0]      o_packed_color
);
    import mmnp_pkg::*;

    localparam int AXW   = SUMW - FB;
    localparam int SCALE = 25599;
    localparam logic signed [DENW-1:0] DEN_ONE_V   = DENW'(100 * (longint'(1) << FB));
    localparam logic signed [DENW-1:0] DEN_THREE_V = DENW'(300 * (longint'(1) << FB));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT,
        ST_RES,
        ST_SUM,
        ST_FIN
    } t_state;

    t_state                  r_state;
    t_entry                  r_ent;
    logic signed [NW-1:0]    r_num [LANES];
    logic signed [DENW-1:0]  r_den [LANES];
    logic                    r_start;
    logic signed [QW-1:0]    r_q [LANES];
    logic signed [SUMW-1:0]  r_sum;
    logic [7:0]              r_byte [LANES];
    logic                    r_out_valid;
    logic [31:0]             r_out_data;

    logic signed [NW-1:0]    mul_n [LANES];
    logic signed [DENW-1:0]  mul_d [LANES];
    logic [LANES-1:0]        div_busy;
    logic signed [QW-1:0]    div_q [LANES];
    logic signed [AXW-1:0]   avg_x;
    logic [19:0]             avg_p;
    logic [7:0]              alpha;
    logic                    fin_fire;

    function automatic logic [7:0] clamp_byte(input logic signed [IW-1:0] x);
        logic [7:0] r;
        if (x < 0) begin
            r = 8'd0;
        end else if (x > IW'(255)) begin
            r = 8'hff;
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mmnp_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_start),
            .i_num   (r_num[g]),
            .i_den   (r_den[g]),
            .o_busy  (div_busy[g]),
            .o_quot  (div_q[g])
        );
    end

    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            mul_n[c] = NW'(r_ent.lanes[c].diff) * NW'(SCALE);
            unique case (r_ent.lanes[c].kind)
                DEN_ZERO:  mul_d[c] = '0;
                DEN_ONE:   mul_d[c] = DEN_ONE_V;
                DEN_THREE: mul_d[c] = DEN_THREE_V;
                DEN_DIFF:  mul_d[c] = DENW'(r_ent.lanes[c].span) * DENW'(100);
                default:   mul_d[c] = '0;
            endcase
        end
    end

    // average of three q16 values, floored and clamped
    always_comb begin
        avg_x = AXW'(r_sum >>> FB);
        avg_p = 20'(avg_x[9:0]) * 20'd683;
        if (avg_x < 0) begin
            alpha = 8'd0;
        end else if (avg_x > AXW'(767)) begin
            alpha = 8'hff;
        end else begin
            alpha = avg_p[18:11];
        end
        if (!r_ent.avg_alpha) begin
            alpha = r_byte[3];
        end
    end

    assign o_q_pop        = (r_state == ST_IDLE) && !i_q_empty;
    assign o_out_valid    = r_out_valid;
    assign o_packed_color = r_out_data;
    assign fin_fire       = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_ent   <= i_q_entry;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    for (int c = 0; c < LANES; c++) begin
                        r_num[c] <= mul_n[c];
                        r_den[c] <= mul_d[c];
                    end
                    r_start <= 1'b1;
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    r_start <= 1'b0;
                    if (!r_start && div_busy == '0) begin
                        r_state <= ST_RES;
                    end
                end
                ST_RES: begin
                    for (int c = 0; c < LANES; c++) begin
                        r_q[c] <= div_q[c];
                    end
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_sum <= SUMW'(r_q[0]) + SUMW'(r_q[1]) + SUMW'(r_q[2]);
                    for (int c = 0; c < LANES; c++) begin
                        r_byte[c] <= clamp_byte(IW'(r_q[c] >>> FB));
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (fin_fire) begin
                        r_out_data <= {r_byte[0], r_byte[1], r_byte[2], alpha};
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/minmax_normalize_rgba_pack.sv
// top level of the min-max normalizing rgba8 packer
// gather words are accepted one per cycle, back to back, while the queue has room
// a convert word is scaled, divided, summed and clamped before its color is registered
// convert rate is set by the 64-step divider in each lane; a new word waits until idle
// two-entry queue lets gathers and further converts enter while a convert is divided
// synchronous active-low reset clears bounds, config registers, queue and output valid
module minmax_normalize_rgba_pack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic               i_first_of_pass,
    input  logic signed [31:0] i_red_sample,
    input  logic signed [31:0] i_green_sample,
    input  logic signed [31:0] i_blue_sample,
    input  logic signed [31:0] i_alpha_sample,
    input  logic               i_alpha_present,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_packed_color
);
    import mmnp_pkg::*;

    t_entry push_entry;
    t_entry pop_entry;
    logic   q_push, q_pop, q_full, q_empty;

    mmnp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_first_of_pass (i_first_of_pass),
        .i_red_sample    (i_red_sample),
        .i_green_sample  (i_green_sample),
        .i_blue_sample   (i_blue_sample),
        .i_alpha_sample  (i_alpha_sample),
        .i_alpha_present (i_alpha_present),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_entry       (push_entry)
    );

    mmnp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_entry (pop_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mmnp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_q_entry      (pop_entry),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_packed_color (o_packed_color)
    );
endmodule
